// ----- rtl/tsbe_pkg.sv -----
// shared types, constants and substitution table for the toy spn block cipher
package tsbe_pkg;

   localparam int BLOCK_WIDTH  = 64;
   localparam int NIBBLE_COUNT = BLOCK_WIDTH / 4;
   localparam int ROUND_WIDTH  = 6;

   localparam logic [ROUND_WIDTH-1:0] ROUND_COUNT_RESET = 6'd20;
   localparam logic [15:0]            KEY_ROUND_CONST   = 16'hF3F3;

   typedef logic [BLOCK_WIDTH-1:0] block_type;
   typedef logic [ROUND_WIDTH-1:0] round_type;

   function automatic logic [3:0] sbox(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hA;
         4'h1: y = 4'h5;
         4'h2: y = 4'h4;
         4'h3: y = 4'h2;
         4'h4: y = 4'h6;
         4'h5: y = 4'h1;
         4'h6: y = 4'hF;
         4'h7: y = 4'h3;
         4'h8: y = 4'hB;
         4'h9: y = 4'hE;
         4'hA: y = 4'h7;
         4'hB: y = 4'h0;
         4'hC: y = 4'h8;
         4'hD: y = 4'hD;
         4'hE: y = 4'hC;
         4'hF: y = 4'h9;
         default: y = 4'h0;
      endcase
      return y;
   endfunction

endpackage

// ----- rtl/tsbe_round.sv -----
// one cipher round and one key schedule step, shared across all rounds
module tsbe_round import tsbe_pkg::*; (
   input  block_type block_in,
   input  block_type key_in,
   output block_type block_out,
   output block_type key_out
);

   logic [3:0] x [NIBBLE_COUNT];
   logic [3:0] o [NIBBLE_COUNT];
   block_type  key_mod;

   always_comb begin
      for (int k = 0; k < NIBBLE_COUNT; k++) begin
         if (k < 8) begin
            x[k] = sbox(block_in[4*k +: 4] ^ key_in[4*k +: 4]);
         end else begin
            x[k] = sbox(block_in[4*k +: 4]);
         end
      end
      for (int i = 0; i < 4; i++) begin
         o[12+i] = x[12+i] ^ x[4+((i+2)&3)];
         o[8+i]  = x[8+((i+3)&3)] ^ x[4+((i+2)&3)];
         o[4+i]  = x[12+i] ^ x[(i+1)&3];
         o[i]    = x[4+((i+2)&3)] ^ x[(i+1)&3];
      end
      for (int k = 0; k < NIBBLE_COUNT; k++) begin
         block_out[4*k +: 4] = o[k];
      end
   end

   // round constant on the low nibbles, then rotate down by four nibbles
   assign key_mod = {key_in[BLOCK_WIDTH-1:16], key_in[15:0] ^ KEY_ROUND_CONST};
   assign key_out = {key_mod[15:0], key_mod[BLOCK_WIDTH-1:16]};

endmodule

// ----- rtl/toy_spn_block_encrypt_top.sv -----
// top level: round sequencer, round count register and output register
//
// usage:
//   req channel (valid/ready) carries one plaintext and one initial key per beat.
//   rsp channel (valid/ready) carries one ciphertext per beat.
//   csr_wr_en/csr_wr_data write the round count (reset value 20); the user must
//   write it only while idle, the block itself does not enforce this.
// each accepted block runs one round per cycle through the single shared round
//   unit, then moves into the output register once that register is free.
// a new req beat is accepted only in idle: req_ready is low while a block
//   is in the loop.
// a finished ciphertext waits in the output register, so the next block can
//   be accepted and run while rsp is stalled; if that block finishes before
//   the first is taken, it holds in the round registers until the output
//   register frees up.
// zero rounds returns the plaintext unchanged.
// reset (synchronous, active high) empties the output register, returns the
//   sequencer to idle and restores the round count to 20.
module toy_spn_block_encrypt_top import tsbe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  block_type              req_plaintext,
   input  block_type              req_cipher_key,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output block_type              rsp_ciphertext,
   input  logic                   csr_wr_en,
   input  logic [ROUND_WIDTH-1:0] csr_wr_data
);

   typedef enum logic {IDLE, RUN} state_type;

   state_type state_ff, state_in;
   round_type round_count_ff, round_count_in;
   round_type remaining_ff, remaining_in;
   block_type block_ff, block_in;
   block_type key_ff, key_in;
   block_type rsp_data_ff, rsp_data_in;
   logic      rsp_valid_ff, rsp_valid_in;
   block_type round_block;
   block_type round_key;
   logic      out_free;

   tsbe_round u_round (
      .block_in  (block_ff),
      .key_in    (key_ff),
      .block_out (round_block),
      .key_out   (round_key)
   );

   assign req_ready      = (state_ff == IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_data_ff;
   assign out_free       = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      remaining_in   = remaining_ff;
      block_in       = block_ff;
      key_in         = key_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      round_count_in = csr_wr_en ? csr_wr_data : round_count_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               block_in     = req_plaintext;
               key_in       = req_cipher_key;
               remaining_in = round_count_ff;
               state_in     = RUN;
            end
         end
         RUN: begin
            if (remaining_ff != '0) begin
               block_in     = round_block;
               key_in       = round_key;
               remaining_in = remaining_ff - 1'b1;
            end else if (out_free) begin
               rsp_data_in  = block_ff;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         rsp_valid_ff   <= 1'b0;
         round_count_ff <= ROUND_COUNT_RESET;
         remaining_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         round_count_ff <= round_count_in;
         remaining_ff   <= remaining_in;
      end
      block_ff    <= block_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == RUN && remaining_ff == $past(round_count_ff)))
      else $error("accepted beat did not start the round loop");

   a_round_countdown: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN && remaining_ff != '0) |=>
         (state_ff == RUN && remaining_ff == $past(remaining_ff) - 1'b1))
      else $error("round counter did not step down");

   a_result_from_loop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (!$past(rsp_valid_ff) || $past(rsp_ready)) && !$past(reset)) |->
         ($past(state_ff) == RUN && $past(remaining_ff) == '0))
      else $error("result beat appeared without a finished round loop");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("waiting result was overwritten");

endmodule

// ----- tb/toy_spn_block_encrypt_top_tb.sv -----
// self-checking testbench for the toy spn block encrypt top level
module toy_spn_block_encrypt_top_tb;
   import tsbe_pkg::*;

   localparam int DIRECTED_ROWS = 20;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 118;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 70;

   localparam block_type ONES = {BLOCK_WIDTH{1'b1}};

   localparam logic [3:0] SUBST [16] = '{
      4'hA, 4'h5, 4'h4, 4'h2, 4'h6, 4'h1, 4'hF, 4'h3,
      4'hB, 4'hE, 4'h7, 4'h0, 4'h8, 4'hD, 4'hC, 4'h9
   };

   typedef struct {
      round_type rounds;
      block_type pt;
      block_type init_key;
      bit        typed;
      block_type ct;
   } vector_row_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   block_type req_plaintext;
   block_type req_cipher_key;
   logic      rsp_valid;
   logic      rsp_ready;
   block_type rsp_ciphertext;
   logic      csr_wr_en;
   round_type csr_wr_data;

   block_type expected_ct [$];
   block_type want_ct;
   round_type rounds_now;
   int        mismatches;
   int        ct_seen;

   vector_row_type directed_rows [DIRECTED_ROWS] = '{
      '{6'd20, 64'h0, 64'h0, 1'b0, 64'h0},
      '{6'd20, ONES, ONES, 1'b0, 64'h0},
      '{6'd20, 64'h0, ONES, 1'b0, 64'h0},
      '{6'd20, ONES, 64'h0, 1'b0, 64'h0},
      '{6'd20, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0},
      '{6'd20, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0, 64'h0},
      '{6'd0, 64'h0, 64'h0, 1'b1, 64'h0},
      '{6'd0, ONES, ONES, 1'b1, ONES},
      '{6'd0, 64'h0123456789ABCDEF, ONES, 1'b1, 64'h0123456789ABCDEF},
      '{6'd0, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'b1, 64'hAAAAAAAAAAAAAAAA},
      '{6'd1, 64'h0, 64'h0, 1'b1, 64'h0},
      '{6'd1, ONES, 64'h0, 1'b1, 64'h0},
      '{6'd1, 64'h0123456789ABCDEF, 64'h0, 1'b0, 64'h0},
      '{6'd1, 64'h8000000000000001, 64'h00000000FFFFFFFF, 1'b0, 64'h0},
      '{6'd63, 64'h0, 64'h0, 1'b0, 64'h0},
      '{6'd63, ONES, ONES, 1'b0, 64'h0},
      '{6'd63, 64'h0F1E2D3C4B5A6978, 64'h8796A5B4C3D2E1F0, 1'b0, 64'h0},
      '{6'd2, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0, 64'h0},
      '{6'd20, 64'h0000000000000001, 64'h8000000000000000, 1'b0, 64'h0},
      '{6'd20, 64'h8000000000000000, 64'h0000000000000001, 1'b0, 64'h0}
   };

   toy_spn_block_encrypt_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_plaintext  (req_plaintext),
      .req_cipher_key (req_cipher_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ciphertext (rsp_ciphertext),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   function automatic block_type encipher(input block_type pt, input block_type init_key,
                                          input round_type rounds);
      logic [3:0] x [16];
      logic [3:0] o [16];
      logic [3:0] k [16];
      logic [3:0] t [16];
      logic [3:0] mid;
      logic [3:0] low;
      block_type  ct;
      int         n;
      int         r;
      for (n = 0; n < NIBBLE_COUNT; n++) begin
         x[n] = pt[4*n +: 4];
         k[n] = init_key[4*n +: 4];
      end
      for (r = 0; r < int'(rounds); r++) begin
         for (n = 0; n < 8; n++) x[n] = x[n] ^ k[n];
         for (n = 0; n < 16; n++) x[n] = SUBST[x[n]];
         for (n = 0; n < 4; n++) begin
            mid = x[4 + ((n + 2) % 4)];
            low = x[(n + 1) % 4];
            o[12 + n] = x[12 + n] ^ mid;
            o[8 + n]  = x[8 + ((n + 3) % 4)] ^ mid;
            o[4 + n]  = x[12 + n] ^ low;
            o[n]      = mid ^ low;
         end
         x = o;
         for (n = 0; n < 4; n++) k[n] = k[n] ^ KEY_ROUND_CONST[4*n +: 4];
         for (n = 0; n < 16; n++) t[n] = k[(n + 4) % 16];
         k = t;
      end
      for (n = 0; n < NIBBLE_COUNT; n++) ct[4*n +: 4] = x[n];
      return ct;
   endfunction

   function automatic block_type random_block();
      block_type v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = ONES;
         2: v = block_type'(1) << $urandom_range(0, BLOCK_WIDTH - 1);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic push_block(input block_type pt, input block_type init_key,
                             input block_type ct);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_plaintext  <= pt;
      req_cipher_key <= init_key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_ct.push_back(ct);
   endtask

   task automatic idle_req(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain();
      idle_req(1);
      while (expected_ct.size() != 0) @(posedge clock);
   endtask

   task automatic set_rounds(input round_type rounds);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rounds;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      rounds_now = rounds;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[toy_spn_block_encrypt_top] ERROR");
      $finish;
   end

   // receiver stall pattern, with one long hold-off to back up the input
   initial begin
      int  style;
      int  span;
      bit  held_off;
      rsp_ready = 1'b0;
      held_off  = 1'b0;
      forever begin
         if (!held_off && ct_seen >= 200) begin
            held_off = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 80);
            repeat (span) begin
               @(negedge clock);
               case (style)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ~rsp_ready;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ct_seen++;
         if (expected_ct.size() == 0) begin
            $display("%0t: unexpected ciphertext beat, actual %h", $time, rsp_ciphertext);
            mismatches++;
         end else begin
            want_ct = expected_ct.pop_front();
            if (rsp_ciphertext !== want_ct) begin
               $display("%0t: ciphertext mismatch, expected %h actual %h",
                        $time, want_ct, rsp_ciphertext);
               mismatches++;
            end
         end
      end
   end

   initial begin
      round_type phase_rounds [PHASES];
      block_type pt;
      block_type init_key;
      int        row;
      int        ph;
      int        sent;
      int        burst;
      int        b;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_plaintext  = '0;
      req_cipher_key = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      mismatches     = 0;
      ct_seen        = 0;
      rounds_now     = ROUND_COUNT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, round count starts at its reset value
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (directed_rows[row].rounds != rounds_now)
            set_rounds(directed_rows[row].rounds);
         push_block(directed_rows[row].pt, directed_rows[row].init_key,
                    directed_rows[row].typed ? directed_rows[row].ct :
                    encipher(directed_rows[row].pt, directed_rows[row].init_key, rounds_now));
      end

      phase_rounds = '{ROUND_COUNT_RESET, 6'd63, 6'd0, 6'd1,
                       round_type'($urandom_range(2, 62)),
                       round_type'($urandom_range(2, 62)),
                       round_type'($urandom_range(2, 62)), 6'd2};

      for (ph = 0; ph < PHASES; ph++) begin
         set_rounds(phase_rounds[ph]);
         sent = 0;
         while (sent < PHASE_BEATS) begin
            if ($urandom_range(0, 4) == 0) burst = $urandom_range(20, 60);
            else burst = $urandom_range(1, 8);
            for (b = 0; b < burst && sent < PHASE_BEATS; b++) begin
               pt       = random_block();
               init_key = random_block();
               push_block(pt, init_key, encipher(pt, init_key, rounds_now));
               sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 8));
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_ct.size() == 0) begin
         $display("[toy_spn_block_encrypt_top] OK");
      end else begin
         $display("[toy_spn_block_encrypt_top] ERROR");
      end
      $finish;
   end

endmodule
